// File: design/arqm_pkg.sv
`default_nettype none

package arqm_pkg;

    // queue depth bound on the overflow limit
    localparam int unsigned MAX_QUEUE   = 255;
    localparam logic [15:0] MAX_QUEUE_W = 16'(MAX_QUEUE);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int MUL_W      = 32;

    // commands
    localparam logic [1:0] CMD_ARRIVAL = 2'd0;
    localparam logic [1:0] CMD_DEPART  = 2'd1;
    localparam logic [1:0] CMD_TICK    = 2'd2;

    // drop causes
    localparam logic [1:0] CAUSE_NONE   = 2'd0;
    localparam logic [1:0] CAUSE_FULL   = 2'd1;
    localparam logic [1:0] CAUSE_RANDOM = 2'd2;
    localparam logic [1:0] CAUSE_FORCED = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_TH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Q_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPREAD  = 3'd5;

    localparam logic [15:0] MAXP_RESET  = 16'd6554;
    localparam logic [9:0]  ONE_PCT_Q16 = 10'd655;
    localparam logic [19:0] CNT_MAX     = 20'hFFFFF;
    // ceil(2^36 / 1000), exact floor division for products below 2^26
    localparam logic [26:0] RECIP_1000  = 27'd68719477;

    typedef struct packed {
        logic [1:0] cmd;
        logic [6:0] rand_pct;
    } t_in_item;

    typedef struct packed {
        logic        admitted;
        logic [1:0]  drop_cause;
        logic [7:0]  queue_length;
        logic [23:0] average_length;
        logic [15:0] max_probability;
        logic [3:0]  load_level;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  min_threshold;
        logic [7:0]  max_threshold;
        logic [7:0]  queue_limit;
        logic [15:0] avg_weight;
        logic [19:0] rate_mean;
        logic [19:0] rate_spread;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        min_threshold: 8'd5,
        max_threshold: 8'd15,
        queue_limit:   8'd35,
        avg_weight:    16'd131,
        rate_mean:     20'd2377,
        rate_spread:   20'd302
    };

    // multiplicative cut factor in thousandths, by load level
    function automatic logic [9:0] cut_factor(input logic [3:0] lvl);
        logic [9:0] f;
        case (lvl)
            4'd1:    f = 10'd830;
            4'd2:    f = 10'd844;
            4'd3:    f = 10'd858;
            4'd4:    f = 10'd872;
            default: f = 10'd900;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

// File: design/arqm_cfg.sv
`default_nettype none

module arqm_cfg import arqm_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_wr_index,
    input  wire logic [CFG_DATA_W-1:0] i_wr_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_wr_en) begin
            case (i_wr_index)
                CFG_MIN_TH:  r_cfg.min_threshold <= i_wr_data[7:0];
                CFG_MAX_TH:  r_cfg.max_threshold <= i_wr_data[7:0];
                CFG_Q_LIMIT: r_cfg.queue_limit   <= i_wr_data[7:0];
                CFG_WEIGHT:  r_cfg.avg_weight    <= i_wr_data[15:0];
                CFG_MEAN:    r_cfg.rate_mean     <= i_wr_data[19:0];
                CFG_SPREAD:  r_cfg.rate_spread   <= i_wr_data[19:0];
                default: begin
                    // writes beyond the register list are ignored
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: design/arqm_mul.sv
`default_nettype none

module arqm_mul import arqm_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic [MUL_W-1:0]     i_a,
    input  wire logic [MUL_W-1:0]     i_b,
    output logic      [2*MUL_W-1:0]   o_prod
);

    logic [2*MUL_W-1:0] r_prod;

    // one multiply per cycle, product registered
    always_ff @(posedge i_clk) begin
        r_prod <= {{MUL_W{1'b0}}, i_a} * {{MUL_W{1'b0}}, i_b};
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// File: design/adaptive_red_queue_manager_top.sv
`default_nettype none

// channel   direction  handshake                  payload
// ------------------------------------------------------------------------------
// in        in         i_in_valid / o_in_ready    i_in_data   (t_in_item)
// out       out        o_out_valid / i_out_ready  o_out_data  (t_out_item)
// cfg       in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// one item at a time through a small sequencer around one shared 32x32 multiplier
// arrival outside the random band, departure, unused command: decode, then finish
// arrival in the random band: three multiplies, two chained, then a compare
// tick: average update, the seven-step level compare loop, then the adapt step;
//   a level-scaled raise adds a raise step, a cut a divide by the reciprocal
// reset is synchronous active low; config returns to defaults, maxp to 0.1
// a finished result waits in the output register while the next item is taken;
//   the sequencer only holds when a second result is ready before the first leaves

module adaptive_red_queue_manager_top import arqm_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // item input
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_item              i_in_data,
    // result output
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out_data,
    // configuration writes
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_A1,
        S_A2,
        S_A3,
        S_A4,
        S_T1,
        S_T2,
        S_T3,
        S_CLS,
        S_ADAPT,
        S_RAISE,
        S_CUT1,
        S_CUT2,
        S_FIN
    } t_state;

    localparam logic [2:0] CLS_LAST = 3'd6;

    // config registers
    t_cfg cfg;

    assign o_cfg_ready = 1'b1;

    arqm_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid & o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    // shared multiplier
    logic [MUL_W-1:0]   mul_a;
    logic [MUL_W-1:0]   mul_b;
    logic [2*MUL_W-1:0] prod;

    arqm_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // architectural state
    t_state             r_state;
    logic [7:0]         r_occ;
    logic [23:0]        r_avg;
    logic [15:0]        r_maxp;
    logic [19:0]        r_cnt;
    logic [3:0]         r_level;

    // per-item working registers
    logic [1:0]         r_cmd;
    logic [6:0]         r_pct;
    logic               r_adm;
    logic [1:0]         r_cause;
    logic [14:0]        r_lhs;
    logic [39:0]        r_acc;
    logic signed [23:0] r_thr;
    logic [3:0]         r_lvl;
    logic [2:0]         r_k;

    // result register
    logic               r_out_valid;
    t_out_item          r_out;

    // arrival decision terms
    logic [15:0] lim16;
    logic        queue_full;
    logic [23:0] min_q;
    logic [23:0] max_q;
    logic        below_min;
    logic        below_max;
    logic [7:0]  th_diff;
    logic [23:0] avg_excess;
    logic        rand_drop;

    // tick terms
    logic [16:0]        w_comp;
    logic [40:0]        tick_sum;
    logic [21:0]        spread3;
    logic signed [23:0] thr0;
    logic               cnt_ge_thr;
    logic [27:0]        ten_avg;
    logic [11:0]        lo_sum;
    logic [11:0]        hi_sum;
    logic [27:0]        lo_target;
    logic [27:0]        hi_target;
    logic [22:0]        maxp100;
    logic               do_raise;
    logic               do_cut;
    logic               lvl_big;
    logic [15:0]        raise_small_add;

    always_comb begin
        // overflow limit is the smaller of the register and the depth bound
        lim16      = (MAX_QUEUE_W < {8'd0, cfg.queue_limit}) ? MAX_QUEUE_W
                                                             : {8'd0, cfg.queue_limit};
        queue_full = ({8'd0, r_occ} >= lim16);
        min_q      = {cfg.min_threshold, 16'd0};
        max_q      = {cfg.max_threshold, 16'd0};
        below_min  = (r_avg < min_q);
        below_max  = (r_avg < max_q);
        // only used inside the random band, where min < max
        th_diff    = cfg.max_threshold - cfg.min_threshold;
        avg_excess = r_avg - min_q;
        // pct*(max-min)*2^32 <= (avg-min)*100*maxp
        rand_drop  = ({r_lhs, 32'd0} <= prod[46:0]);

        w_comp   = 17'h10000 - {1'b0, cfg.avg_weight};
        // round to nearest, half up
        tick_sum = {1'b0, r_acc} + {1'b0, prod[23:0], 16'd0} + 41'd32768;

        // lowest band edge is mean - 3*spread, then step by spread
        spread3    = {2'd0, cfg.rate_spread} + {1'b0, cfg.rate_spread, 1'b0};
        thr0       = $signed({4'd0, cfg.rate_mean}) - $signed({2'd0, spread3});
        cnt_ge_thr = ($signed({4'd0, r_cnt}) >= r_thr);

        // targets at 40% and 60% of the band, scaled by 10
        ten_avg   = {1'b0, r_avg, 3'd0} + {3'd0, r_avg, 1'b0};
        lo_sum    = 12'(cfg.min_threshold) * 12'd6 + 12'(cfg.max_threshold) * 12'd4;
        hi_sum    = 12'(cfg.min_threshold) * 12'd4 + 12'(cfg.max_threshold) * 12'd6;
        lo_target = {lo_sum, 16'd0};
        hi_target = {hi_sum, 16'd0};
        maxp100   = 23'(r_maxp) * 23'd100;

        do_raise  = (ten_avg > hi_target) && !r_maxp[15];
        do_cut    = !do_raise && (ten_avg < lo_target) && (maxp100 > 23'd65536);
        lvl_big   = (r_lvl >= 4'd5);
        // light load: quarter of maxp, capped at one percent above four percent
        raise_small_add = (maxp100 > 23'd262144) ? 16'(ONE_PCT_Q16)
                                                 : {2'd0, r_maxp[15:2]};
    end

    // multiplier operand select by sequencer step
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_A1: begin
                mul_a = 32'(r_pct);
                mul_b = 32'(th_diff);
            end
            S_A2: begin
                mul_a = 32'(avg_excess);
                mul_b = 32'd100;
            end
            S_A3: begin
                mul_a = 32'(prod[30:0]);
                mul_b = 32'(r_maxp);
            end
            S_T1: begin
                mul_a = 32'(r_avg);
                mul_b = 32'(w_comp);
            end
            S_T2: begin
                mul_a = 32'(r_occ);
                mul_b = 32'(cfg.avg_weight);
            end
            S_ADAPT: begin
                mul_a = 32'(r_maxp);
                mul_b = do_raise ? 32'(r_lvl - 4'd1) : 32'(cut_factor(r_lvl));
            end
            S_CUT1: begin
                // divide by 1000 through the reciprocal
                mul_a = 32'(prod[25:0]);
                mul_b = 32'(RECIP_1000);
            end
            default: begin
            end
        endcase
    end

    // sequencer, state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_occ       <= '0;
            r_avg       <= '0;
            r_maxp      <= MAXP_RESET;
            r_cnt       <= '0;
            r_level     <= '0;
        end else begin
            // the finish step reloads the result register itself
            if (r_out_valid && i_out_ready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd   <= i_in_data.cmd;
                        r_pct   <= i_in_data.rand_pct;
                        r_adm   <= 1'b0;
                        r_cause <= CAUSE_NONE;
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    case (r_cmd)
                        CMD_ARRIVAL: begin
                            // every arrival counts, saturating
                            if (r_cnt != CNT_MAX) begin
                                r_cnt <= r_cnt + 20'd1;
                            end
                            if (queue_full) begin
                                r_cause <= CAUSE_FULL;
                                r_state <= S_FIN;
                            end else if (below_min) begin
                                r_adm   <= 1'b1;
                                r_occ   <= r_occ + 8'd1;
                                r_state <= S_FIN;
                            end else if (below_max) begin
                                r_state <= S_A1;
                            end else begin
                                r_cause <= CAUSE_FORCED;
                                r_state <= S_FIN;
                            end
                        end
                        CMD_DEPART: begin
                            if (r_occ != 8'd0) begin
                                r_occ <= r_occ - 8'd1;
                            end
                            r_state <= S_FIN;
                        end
                        CMD_TICK: begin
                            r_state <= S_T1;
                        end
                        default: begin
                            // unused command only reports status
                            r_state <= S_FIN;
                        end
                    endcase
                end
                S_A1: begin
                    r_state <= S_A2;
                end
                S_A2: begin
                    r_lhs   <= prod[14:0];
                    r_state <= S_A3;
                end
                S_A3: begin
                    r_state <= S_A4;
                end
                S_A4: begin
                    if (rand_drop) begin
                        r_cause <= CAUSE_RANDOM;
                    end else begin
                        r_adm <= 1'b1;
                        r_occ <= r_occ + 8'd1;
                    end
                    r_state <= S_FIN;
                end
                S_T1: begin
                    r_state <= S_T2;
                end
                S_T2: begin
                    r_acc   <= prod[39:0];
                    r_state <= S_T3;
                end
                S_T3: begin
                    r_avg   <= tick_sum[39:16];
                    r_thr   <= thr0;
                    r_lvl   <= 4'd1;
                    r_k     <= '0;
                    r_state <= S_CLS;
                end
                S_CLS: begin
                    if (cnt_ge_thr) begin
                        r_lvl <= r_lvl + 4'd1;
                    end
                    r_thr <= r_thr + $signed({4'd0, cfg.rate_spread});
                    r_k   <= r_k + 3'd1;
                    if (r_k == CLS_LAST) begin
                        r_state <= S_ADAPT;
                    end
                end
                S_ADAPT: begin
                    r_level <= r_lvl;
                    r_cnt   <= '0;
                    if (do_raise) begin
                        if (lvl_big) begin
                            r_state <= S_RAISE;
                        end else begin
                            r_maxp  <= r_maxp + raise_small_add;
                            r_state <= S_FIN;
                        end
                    end else if (do_cut) begin
                        r_state <= S_CUT1;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_RAISE: begin
                    // heavy load: maxp*(level-1)/32
                    r_maxp  <= r_maxp + prod[20:5];
                    r_state <= S_FIN;
                end
                S_CUT1: begin
                    r_state <= S_CUT2;
                end
                S_CUT2: begin
                    r_maxp  <= prod[51:36];
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid           <= 1'b1;
                        r_out.admitted        <= r_adm;
                        r_out.drop_cause      <= r_cause;
                        r_out.queue_length    <= r_occ;
                        r_out.average_length  <= r_avg;
                        r_out.max_probability <= r_maxp;
                        r_out.load_level      <= r_level;
                        r_state               <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // arrival counter is cleared once the tick has classified it
    a_cnt_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADAPT) |=> (r_cnt == '0))
        else $error("arrival count not cleared after tick");

    // a tick always lands on a level from 1 to 8
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADAPT) |=> (r_level >= 4'd1 && r_level <= 4'd8))
        else $error("load level out of range after tick");

    // a loaded result is valid and never both admitted and dropped
    a_result_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && (!r_out_valid || i_out_ready)) |=>
        (o_out_valid && !(o_out_data.admitted && o_out_data.drop_cause != CAUSE_NONE)))
        else $error("result loaded with conflicting admit and drop");

    // the sequencer takes one item and is busy on the next cycle
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second item accepted while busy");

endmodule

`default_nettype wire
